[rtl/assert_macros.svh]
// Assertion macros shared by the voltmeter RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/vmmr_pkg.sv]
// Package for the voltmeter min/max reporter: codes, sizes and helper functions.
// No dependencies; imported by voltmeter_min_max_reporter.
`timescale 1ns / 1ps

package vmmr_pkg;

    // samples per averaged group, kept a power of two so the average is a shift
    localparam int SAMPLES_LOG2        = 3;
    localparam int SAMPLES_PER_AVERAGE = 1 << SAMPLES_LOG2;

    localparam int SAMPLE_W = 10;
    localparam int CHAR_W   = 8;
    localparam int SUM_W    = SAMPLE_W + SAMPLES_LOG2;
    localparam int LEVEL_W  = 6;
    localparam int BCD_W    = 6;
    localparam int IDX_W    = 4;

    // level limits in tenths of a volt
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(33);
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = '0;

    // input kind codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CHAR   = 1'b1;

    // result kind codes
    localparam logic RK_DISPLAY = 1'b0;
    localparam logic RK_TX      = 1'b1;

    // query characters
    localparam logic [CHAR_W-1:0] CHAR_QUERY_MAX = 8'h4D;  // 'M'
    localparam logic [CHAR_W-1:0] CHAR_QUERY_MIN = 8'h6D;  // 'm'

    // byte positions of the reply text
    localparam logic [IDX_W-1:0] REPLY_FIRST = 4'd0;
    localparam logic [IDX_W-1:0] REPLY_LAST  = 4'd9;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NEWLINE = 8'h0A;

    // (33*avg + 511) / 1023; the remainder after x>>10 stays below 2*1023
    function automatic logic [LEVEL_W-1:0] scale_level(input logic [SAMPLE_W-1:0] avg);
        logic [15:0] scaled;
        logic [5:0]  q0;
        logic [10:0] rem;
        scaled = 16'(avg) * 16'd33 + 16'd511;
        q0     = scaled[15:10];
        rem    = 11'(scaled[9:0]) + 11'(q0);
        return LEVEL_W'(q0 + ((rem >= 11'd1023) ? 6'd1 : 6'd0));
    endfunction

    // packed bcd of a level 0..33: tens above, tenths in the low nibble
    function automatic logic [BCD_W-1:0] level_to_bcd(input logic [LEVEL_W-1:0] level);
        logic [1:0]         tens;
        logic [LEVEL_W-1:0] units;
        if (level >= LEVEL_W'(30)) begin
            tens  = 2'd3;
            units = level - LEVEL_W'(30);
        end else if (level >= LEVEL_W'(20)) begin
            tens  = 2'd2;
            units = level - LEVEL_W'(20);
        end else if (level >= LEVEL_W'(10)) begin
            tens  = 2'd1;
            units = level - LEVEL_W'(10);
        end else begin
            tens  = 2'd0;
            units = level;
        end
        return {tens, units[3:0]};
    endfunction

    // one byte of "VMax=d.dV\n" or "VMin=d.dV\n"
    function automatic logic [CHAR_W-1:0] reply_byte(input logic             is_max,
                                                     input logic [BCD_W-1:0] bcd,
                                                     input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] b;
        case (idx)
            4'd0:    b = 8'h56;                          // 'V'
            4'd1:    b = 8'h4D;                          // 'M'
            4'd2:    b = is_max ? 8'h61 : 8'h69;         // 'a' / 'i'
            4'd3:    b = is_max ? 8'h78 : 8'h6E;         // 'x' / 'n'
            4'd4:    b = 8'h3D;                          // '='
            4'd5:    b = ASCII_ZERO + CHAR_W'(bcd[5:4]);
            4'd6:    b = 8'h2E;                          // '.'
            4'd7:    b = ASCII_ZERO + CHAR_W'(bcd[3:0]);
            4'd8:    b = 8'h56;                          // 'V'
            4'd9:    b = ASCII_NEWLINE;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/voltmeter_min_max_reporter.sv]
// Voltmeter min/max reporter: sample averaging, level scaling and query replies.
// Depends on vmmr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Input stream (s_*): s_tuser is the item kind (0 sample, 1 received character),
//   s_tdata carries the 10-bit sample and the 8-bit character.
//   Output stream (m_*): m_tuser is the result kind (0 display update, 1 transmit
//   byte), m_tdata carries the display bcd and the transmit byte, m_tlast marks
//   the final result of an input item.
//   Every eighth sample yields one display update; 'M' or 'm' yields the ten
//   bytes of the max or min reply; anything else yields nothing.
//   Path: an accepted item waits in the input register, and its result is loaded
//   from there into the output register, which drives the m_* stream.
//   Throughput: one item per cycle while the output is free; a query holds the
//   input register for its ten bytes, one at a time via the single output register.
//   Reset (aresetn low, synchronous) empties both registers, clears the running
//   sum and count, sets the lowest level to 3.3 V and the highest to 0.
//   When m_tready is low the output register holds; the input register still
//   takes one more item, and s_tready drops once that item also has to wait.

module voltmeter_min_max_reporter
    import vmmr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] sample, [17:10] rx_char, [23:18] zero
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] display_bcd, [13:6] tx_byte, [15:14] zero
    output logic        m_tuser,   // [0] result_kind
    output logic        m_tlast
);

    // input register
    logic                in_valid_reg, in_valid_next;
    logic                in_kind_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic [CHAR_W-1:0]   in_char_reg;

    // block state
    logic [SUM_W-1:0]        sample_sum_reg, sample_sum_next;
    logic [SAMPLES_LOG2-1:0] sample_count_reg, sample_count_next;
    logic [LEVEL_W-1:0]      lowest_level_reg, lowest_level_next;
    logic [LEVEL_W-1:0]      highest_level_reg, highest_level_next;
    logic [IDX_W-1:0]        byte_idx_reg, byte_idx_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg;
    logic [BCD_W-1:0]  out_bcd_reg;
    logic [CHAR_W-1:0] out_tx_reg;
    logic              out_last_reg;

    logic                s_accept;
    logic [SUM_W-1:0]    sum_ext;
    logic [SAMPLE_W-1:0] avg;
    logic [LEVEL_W-1:0]  level;
    logic                is_sample, group_done, is_query, is_max, has_result;
    logic                out_free, last_byte, in_advance, out_load;
    logic [BCD_W-1:0]    query_bcd;

    // item decode and level computation from the input register
    always_comb begin
        is_sample  = (in_kind_reg == KIND_SAMPLE);
        sum_ext    = sample_sum_reg + SUM_W'(in_sample_reg);
        group_done = is_sample &&
                     (sample_count_reg == SAMPLES_LOG2'(SAMPLES_PER_AVERAGE - 1));
        avg        = SAMPLE_W'(sum_ext >> SAMPLES_LOG2);
        level      = scale_level(avg);
        is_max     = (in_char_reg == CHAR_QUERY_MAX);
        is_query   = !is_sample && (is_max || (in_char_reg == CHAR_QUERY_MIN));
        has_result = group_done || is_query;
        query_bcd  = level_to_bcd(is_max ? highest_level_reg : lowest_level_reg);
    end

    // handshake between the input and output registers
    always_comb begin
        out_free   = !out_valid_reg || m_tready;
        last_byte  = (byte_idx_reg == REPLY_LAST);
        out_load   = in_valid_reg && has_result && out_free;
        in_advance = in_valid_reg && (!has_result || (out_free && (!is_query || last_byte)));
        s_tready   = !in_valid_reg || in_advance;
        s_accept   = s_tvalid && s_tready;
    end

    // next state
    always_comb begin
        in_valid_next      = s_accept ? 1'b1 : (in_advance ? 1'b0 : in_valid_reg);
        sample_sum_next    = sample_sum_reg;
        sample_count_next  = sample_count_reg;
        lowest_level_next  = lowest_level_reg;
        highest_level_next = highest_level_reg;
        byte_idx_next      = byte_idx_reg;

        // running sum and group bookkeeping
        if (in_advance && is_sample) begin
            if (group_done) begin
                sample_sum_next   = '0;
                sample_count_next = '0;
                if (level < lowest_level_reg) begin
                    lowest_level_next = level;
                end
                if (level > highest_level_reg) begin
                    highest_level_next = level;
                end
            end else begin
                sample_sum_next   = sum_ext;
                sample_count_next = sample_count_reg + 1'b1;
            end
        end

        // reply byte sequencer
        if (out_load && is_query) begin
            byte_idx_next = last_byte ? REPLY_FIRST : byte_idx_reg + 1'b1;
        end

        out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            byte_idx_reg      <= REPLY_FIRST;
            sample_sum_reg    <= '0;
            sample_count_reg  <= '0;
            lowest_level_reg  <= LEVEL_MAX;
            highest_level_reg <= LEVEL_MIN;
        end else begin
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            byte_idx_reg      <= byte_idx_next;
            sample_sum_reg    <= sample_sum_next;
            sample_count_reg  <= sample_count_next;
            lowest_level_reg  <= lowest_level_next;
            highest_level_reg <= highest_level_next;
        end
    end

    // input payload capture on transfer
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg   <= s_tuser;
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
            in_char_reg   <= s_tdata[SAMPLE_W+CHAR_W-1:SAMPLE_W];
        end
    end

    // output payload load
    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (is_query) begin
                out_kind_reg <= RK_TX;
                out_bcd_reg  <= '0;
                out_tx_reg   <= reply_byte(is_max, query_bcd, byte_idx_reg);
                out_last_reg <= last_byte;
            end else begin
                out_kind_reg <= RK_DISPLAY;
                out_bcd_reg  <= level_to_bcd(level);
                out_tx_reg   <= '0;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_tx_reg, out_bcd_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // checks
    `ASSERT_ALWAYS(a_level_range,
        (lowest_level_reg <= LEVEL_MAX) && (highest_level_reg <= LEVEL_MAX),
        "tracked level above 3.3 V")
    `ASSERT_ALWAYS(a_byte_idx_range, byte_idx_reg <= REPLY_LAST,
        "reply byte index past end of text")
    `ASSERT_IMPLIES(a_reply_owner, byte_idx_reg != REPLY_FIRST,
        in_valid_reg && is_query, "reply in progress without a held query")
    `ASSERT_IMPLIES(a_reply_ends_newline, out_valid_reg && out_kind_reg == RK_TX && out_last_reg,
        out_tx_reg == ASCII_NEWLINE, "reply does not end in a newline")

endmodule
